FILE: sv/fmbq_pkg.sv
// ----------------------------------------------------------------------------
// fmbq_pkg
// Shared constants and types for the front/middle/back queue: ring geometry,
// command and status codes, and the controller-to-datapath command bundle.
// ----------------------------------------------------------------------------
package fmbq_pkg;

	// Ring geometry. Ring indexes wrap by natural overflow, so HALF_DEPTH is a
	// power of two.
	localparam int HALF_DEPTH = 512;
	localparam int IDX_W      = $clog2(HALF_DEPTH);
	localparam int SIZE_W     = IDX_W + 1;
	localparam int COUNT_W    = SIZE_W + 1;
	localparam int DATA_W     = 32;

	// Command codes.
	localparam logic [2:0] CMD_PUSH_FRONT  = 3'd0;
	localparam logic [2:0] CMD_PUSH_MIDDLE = 3'd1;
	localparam logic [2:0] CMD_PUSH_BACK   = 3'd2;
	localparam logic [2:0] CMD_POP_FRONT   = 3'd3;
	localparam logic [2:0] CMD_POP_MIDDLE  = 3'd4;
	localparam logic [2:0] CMD_POP_BACK    = 3'd5;

	// Status codes.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;    // capture the incoming word
		logic commit;  // perform writes, update pointers, issue the result
	} ctl_t;

endpackage

FILE: sv/fmbq_ram.sv
// ----------------------------------------------------------------------------
// fmbq_ram
// One ring half: a simple dual-port memory with one write port and one
// registered read port. A read in the same cycle as a write returns old data.
// ----------------------------------------------------------------------------
module fmbq_ram
	import fmbq_pkg::*;
(
	input  logic              clk,
	input  logic              we,
	input  logic [IDX_W-1:0]  waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [IDX_W-1:0]  raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [HALF_DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

FILE: sv/fmbq_dp.sv
// ----------------------------------------------------------------------------
// fmbq_dp
// Datapath: the two ring halves, their head and size registers, the decode of
// each request into reads, writes and pointer updates, and the result word.
// ----------------------------------------------------------------------------
module fmbq_dp
	import fmbq_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  ctl_t                      ctl,
	input  logic [2:0]                cmd,
	input  logic signed [DATA_W-1:0]  push_value,
	output logic                      done,
	output logic signed [DATA_W-1:0]  pop_value,
	output logic [1:0]                status,
	output logic [COUNT_W-1:0]        element_count
);

	localparam logic [1:0] POP_NONE  = 2'd0;
	localparam logic [1:0] POP_FRONT = 2'd1;
	localparam logic [1:0] POP_BACK  = 2'd2;

	// Captured request.
	logic [2:0]        cmd_q;
	logic [DATA_W-1:0] val_q;

	// Ring pointers.
	logic [IDX_W-1:0]  fhead_q, bhead_q;
	logic [SIZE_W-1:0] fsize_q, bsize_q;

	// Result registers.
	logic              done_q;
	logic [DATA_W-1:0] pop_value_q;
	logic [1:0]        status_q;
	logic [COUNT_W-1:0] count_q;

	// Derived ring addresses.
	logic [IDX_W-1:0] f_last, f_end, f_prev, f_next;
	logic [IDX_W-1:0] b_last, b_end, b_prev, b_next;
	logic [COUNT_W-1:0] total;
	logic full, empty, sizes_eq;

	// Per-request plan.
	logic [IDX_W-1:0]  fr_raddr, br_raddr, fw_addr, bw_addr;
	logic              fw_en, bw_en, fw_from_back, bw_from_front;
	logic [1:0]        pop_sel, st;
	logic [IDX_W-1:0]  nfh, nbh;
	logic [SIZE_W-1:0] nfs, nbs;

	// Memory data.
	logic [DATA_W-1:0] f_rdata, b_rdata, f_wdata, b_wdata;

	assign f_last = fhead_q + fsize_q[IDX_W-1:0] - 1'b1;
	assign f_end  = fhead_q + fsize_q[IDX_W-1:0];
	assign f_prev = fhead_q - 1'b1;
	assign f_next = fhead_q + 1'b1;
	assign b_last = bhead_q + bsize_q[IDX_W-1:0] - 1'b1;
	assign b_end  = bhead_q + bsize_q[IDX_W-1:0];
	assign b_prev = bhead_q - 1'b1;
	assign b_next = bhead_q + 1'b1;

	assign total    = COUNT_W'(fsize_q) + COUNT_W'(bsize_q);
	assign full     = total >= COUNT_W'(2 * HALF_DEPTH);
	assign empty    = total == '0;
	assign sizes_eq = fsize_q == bsize_q;

	// Decode the captured request against the current balance. The back half
	// holds either as many elements as the front half or exactly one more.
	always_comb begin
		fr_raddr      = f_last;
		br_raddr      = bhead_q;
		fw_en         = 1'b0;
		fw_addr       = f_end;
		fw_from_back  = 1'b0;
		bw_en         = 1'b0;
		bw_addr       = b_prev;
		bw_from_front = 1'b0;
		pop_sel       = POP_NONE;
		st            = ST_OK;
		nfh           = fhead_q;
		nfs           = fsize_q;
		nbh           = bhead_q;
		nbs           = bsize_q;
		case (cmd_q)
			CMD_PUSH_FRONT: begin
				if (full) begin
					st = ST_FULL;
				end else if (sizes_eq && fsize_q == '0) begin
					// The new word goes straight to the back half.
					bw_en = 1'b1;
					bw_addr = b_prev;
					nbh = b_prev;
					nbs = bsize_q + 1'b1;
				end else if (sizes_eq) begin
					// Prepend, and the old front tail moves to the back half.
					fr_raddr = f_last;
					fw_en = 1'b1;
					fw_addr = f_prev;
					bw_en = 1'b1;
					bw_addr = b_prev;
					bw_from_front = 1'b1;
					nfh = f_prev;
					nbh = b_prev;
					nbs = bsize_q + 1'b1;
				end else begin
					fw_en = 1'b1;
					fw_addr = f_prev;
					nfh = f_prev;
					nfs = fsize_q + 1'b1;
				end
			end
			CMD_PUSH_MIDDLE: begin
				if (full) begin
					st = ST_FULL;
				end else if (sizes_eq) begin
					bw_en = 1'b1;
					bw_addr = b_prev;
					nbh = b_prev;
					nbs = bsize_q + 1'b1;
				end else begin
					fw_en = 1'b1;
					fw_addr = f_end;
					nfs = fsize_q + 1'b1;
				end
			end
			CMD_PUSH_BACK: begin
				if (full) begin
					st = ST_FULL;
				end else if (sizes_eq) begin
					bw_en = 1'b1;
					bw_addr = b_end;
					nbs = bsize_q + 1'b1;
				end else begin
					// The back head moves to the front tail, then append.
					br_raddr = bhead_q;
					fw_en = 1'b1;
					fw_addr = f_end;
					fw_from_back = 1'b1;
					bw_en = 1'b1;
					bw_addr = b_end;
					nbh = b_next;
					nfs = fsize_q + 1'b1;
				end
			end
			CMD_POP_FRONT: begin
				if (empty) begin
					st = ST_EMPTY;
				end else if (fsize_q == '0) begin
					br_raddr = bhead_q;
					pop_sel = POP_BACK;
					nbh = b_next;
					nbs = bsize_q - 1'b1;
				end else if (!sizes_eq) begin
					// Pop the front head and refill from the back head.
					fr_raddr = fhead_q;
					br_raddr = bhead_q;
					pop_sel = POP_FRONT;
					fw_en = 1'b1;
					fw_addr = f_end;
					fw_from_back = 1'b1;
					nfh = f_next;
					nbh = b_next;
					nbs = bsize_q - 1'b1;
				end else begin
					fr_raddr = fhead_q;
					pop_sel = POP_FRONT;
					nfh = f_next;
					nfs = fsize_q - 1'b1;
				end
			end
			CMD_POP_MIDDLE: begin
				if (empty) begin
					st = ST_EMPTY;
				end else if (sizes_eq) begin
					fr_raddr = f_last;
					pop_sel = POP_FRONT;
					nfs = fsize_q - 1'b1;
				end else begin
					br_raddr = bhead_q;
					pop_sel = POP_BACK;
					nbh = b_next;
					nbs = bsize_q - 1'b1;
				end
			end
			CMD_POP_BACK: begin
				if (empty) begin
					st = ST_EMPTY;
				end else if (sizes_eq) begin
					// Pop the back tail; the front tail moves to the back head.
					br_raddr = b_last;
					fr_raddr = f_last;
					pop_sel = POP_BACK;
					bw_en = 1'b1;
					bw_addr = b_prev;
					bw_from_front = 1'b1;
					nbh = b_prev;
					nfs = fsize_q - 1'b1;
				end else begin
					br_raddr = b_last;
					pop_sel = POP_BACK;
					nbs = bsize_q - 1'b1;
				end
			end
			default: begin
				st = ST_OK;
			end
		endcase
	end

	assign f_wdata = fw_from_back ? b_rdata : val_q;
	assign b_wdata = bw_from_front ? f_rdata : val_q;

	// Ring halves.
	fmbq_ram u_front (
		.clk   (clk),
		.we    (ctl.commit && fw_en),
		.waddr (fw_addr),
		.wdata (f_wdata),
		.raddr (fr_raddr),
		.rdata (f_rdata)
	);

	fmbq_ram u_back (
		.clk   (clk),
		.we    (ctl.commit && bw_en),
		.waddr (bw_addr),
		.wdata (b_wdata),
		.raddr (br_raddr),
		.rdata (b_rdata)
	);

	// Capture the incoming word.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= cmd;
			val_q <= push_value;
		end
	end

	// Pointer and strobe registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fhead_q <= '0;
			fsize_q <= '0;
			bhead_q <= '0;
			bsize_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= ctl.commit;
			if (ctl.commit) begin
				fhead_q <= nfh;
				fsize_q <= nfs;
				bhead_q <= nbh;
				bsize_q <= nbs;
			end
		end
	end

	// Result word.
	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			status_q <= st;
			count_q  <= COUNT_W'(nfs) + COUNT_W'(nbs);
			case (pop_sel)
				POP_FRONT: pop_value_q <= f_rdata;
				POP_BACK:  pop_value_q <= b_rdata;
				default:   pop_value_q <= '0;
			endcase
		end
	end

	assign done          = done_q;
	assign pop_value     = pop_value_q;
	assign status        = status_q;
	assign element_count = count_q;

endmodule

FILE: sv/fmbq_ctrl.sv
// ----------------------------------------------------------------------------
// fmbq_ctrl
// Controller: sequences each request through a read state and a write state
// and tells the datapath when to capture a word and when to commit it.
// ----------------------------------------------------------------------------
module fmbq_ctrl
	import fmbq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	output ctl_t ctl
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_READ = 2'd1;
	localparam logic [1:0] S_WRITE = 2'd2;

	logic [1:0] state_q, state_d;

	// Next-state logic.
	always_comb begin
		case (state_q)
			S_IDLE:  state_d = start ? S_READ : S_IDLE;
			S_READ:  state_d = S_WRITE;
			S_WRITE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Commands to the datapath.
	assign busy       = state_q != S_IDLE;
	assign ctl.load   = (state_q == S_IDLE) && start;
	assign ctl.commit = state_q == S_WRITE;

endmodule

FILE: sv/front_middle_back_queue_top.sv
// ----------------------------------------------------------------------------
// front_middle_back_queue_top
// A queue of signed 32-bit words with push and pop at the front, the middle
// and the back, held as two balanced ring halves.
// done rises once a request has passed its read and write states and its
// commit is registered. A new word is accepted only in the idle state: busy
// stays high while a request is in its read and write states on the rings.
// Reset clears the controller, heads and sizes; ring contents are undefined.
// Results cannot be stalled: each result is valid for the one cycle of done.
// ----------------------------------------------------------------------------
module front_middle_back_queue_top
	import fmbq_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [2:0]                cmd,
	input  logic signed [DATA_W-1:0]  push_value,
	output logic                      done,
	output logic signed [DATA_W-1:0]  pop_value,
	output logic [1:0]                status,
	output logic [COUNT_W-1:0]        element_count
);

	ctl_t ctl;

	// Sequencer.
	fmbq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.ctl    (ctl)
	);

	// Rings, pointers and result word.
	fmbq_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.cmd           (cmd),
		.push_value    (push_value),
		.done          (done),
		.pop_value     (pop_value),
		.status        (status),
		.element_count (element_count)
	);

endmodule
